// File: src/bpsk_md_pkg.sv
// Shared types and constants for the BPSK impulse modulator and loopback demodulator.
`timescale 1ns / 1ps

package bpsk_md_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_SAMPLES_PER_SYMBOL = 20;
  localparam int DEF_SYMBOL_SPAN        = 8;
  localparam int DEF_COEF_WIDTH         = 16;

  // Fixed field widths
  localparam int PHASE_W    = 5;
  localparam int IDX_W      = 8;
  localparam int SAMPLE_W   = 16;
  localparam int AMP_W      = 15;
  localparam int GAIN_W     = 16;
  localparam int LPF_COEF_W = 18;
  localparam int LPF_Y_W    = 32;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 2;

  // Register reset values
  localparam logic [AMP_W-1:0]             AMP_RESET  = 15'd15000;
  localparam logic [GAIN_W-1:0]            GAIN_RESET = 16'd1316;
  localparam logic signed [LPF_COEF_W-1:0] A1_RESET   = -18'sd102303;
  localparam logic signed [LPF_COEF_W-1:0] A2_RESET   = 18'sd42032;

  // Item operations
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYMBOL_AMPLITUDE = 2'd0,
    REG_LPF_GAIN         = 2'd1,
    REG_LPF_A1           = 2'd2,
    REG_LPF_A2           = 2'd3
  } cfg_reg_t;

  // Symbol history levels
  typedef enum logic [1:0] {
    LVL_EMPTY = 2'd0,
    LVL_POS   = 2'd1,
    LVL_NEG   = 2'd2
  } level_t;

endpackage

// File: src/bpsk_md_taps.sv
// Coefficient memory and polyphase tap accumulator of the BPSK modulator.
`timescale 1ns / 1ps

module bpsk_md_taps
  import bpsk_md_pkg::*;
#(
  parameter int SAMPLES_PER_SYMBOL = DEF_SAMPLES_PER_SYMBOL,
  parameter int SYMBOL_SPAN        = DEF_SYMBOL_SPAN,
  parameter int COEF_WIDTH         = DEF_COEF_WIDTH,
  localparam int DEPTH = SAMPLES_PER_SYMBOL * SYMBOL_SPAN,
  localparam int AW    = $clog2(DEPTH),
  localparam int SW    = COEF_WIDTH + $clog2(SYMBOL_SPAN) + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic signed [COEF_WIDTH-1:0] wr_data,
  input  logic                         start,
  input  logic [PHASE_W-1:0]           phase,
  input  level_t                       hist [SYMBOL_SPAN],
  output logic                         done,
  output logic signed [SW-1:0]         csum
);

  localparam int TCW = $clog2(SYMBOL_SPAN + 1);
  localparam int TIW = $clog2(SYMBOL_SPAN);

  logic signed [COEF_WIDTH-1:0] mem [DEPTH];
  logic signed [COEF_WIDTH-1:0] rdata;
  logic [AW-1:0]                addr;
  logic [TCW-1:0]               rd_tap;
  logic [TIW-1:0]               acc_tap;
  logic                         rd_pend;
  logic                         busy;
  logic                         rd_en;

  // one tap read a cycle; the read data is registered and accumulated in the next cycle
  assign rd_en = busy && (rd_tap != TCW'(SYMBOL_SPAN));
  assign done  = busy && rd_pend && !rd_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (start) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      addr   <= AW'(phase);
      rd_tap <= '0;
      csum   <= '0;
    end else begin
      if (rd_en) begin
        addr    <= addr + AW'(SAMPLES_PER_SYMBOL);
        rd_tap  <= rd_tap + TCW'(1);
        acc_tap <= rd_tap[TIW-1:0];
      end
      if (rd_pend) begin
        unique case (hist[acc_tap])
          LVL_POS: csum <= csum + SW'(rdata);
          LVL_NEG: csum <= csum - SW'(rdata);
          default: csum <= csum;
        endcase
      end
    end
  end

endmodule

// File: src/bpsk_impulse_modulator_demod.sv
// Top level of the impulse-modulated BPSK transmitter with loopback demodulator.
`timescale 1ns / 1ps

// A load item (operation = 1) writes one Q1.15 pulse-shaping coefficient at
// coef_index = phase + SAMPLES_PER_SYMBOL * tap and leaves the block idle; indexes
// beyond the store are dropped and give no result. A sample item
// (operation = 0) gives exactly one result and keeps in_ready low until it
// has been placed in the output register: the taps are read one a cycle from
// the coefficient memory into the tap accumulator, then the scaling, mixing
// and biquad terms go one after another through one shared 32x18 multiplier.
// in_ready is high only between items; a finished result sits in the output
// register, so the next item is taken while it waits for out_ready. The
// coefficient store has no reset and needs no clearing pass: every entry a
// sample can touch must be loaded before the first sample item. At phase 0
// the item's symbol_bit enters the symbol history (1 = +amplitude,
// 0 = -amplitude); the history starts empty. baseband_sample is the rounded
// polyphase FIR output; recovered_sample is that value mixed with the
// quarter-rate carrier, demodulated by twice the carrier and low-passed by a
// direct form I biquad (1,2,1 numerator, Q0.16 gain, Q16 a1/a2). Both outputs
// saturate to 16 bits. Registers are written through cfg_write / cfg_index /
// cfg_data; the user must do so only while the block is idle (not enforced).

module bpsk_impulse_modulator_demod
  import bpsk_md_pkg::*;
#(
  parameter int SAMPLES_PER_SYMBOL = DEF_SAMPLES_PER_SYMBOL,
  parameter int SYMBOL_SPAN        = DEF_SYMBOL_SPAN,
  parameter int COEF_WIDTH         = DEF_COEF_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  // input items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic                        symbol_bit,
  input  logic [IDX_W-1:0]            coef_index,
  input  logic signed [SAMPLE_W-1:0]  coef_value,
  // results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  baseband_sample,
  output logic signed [SAMPLE_W-1:0]  recovered_sample,
  // register writes
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int STORE_DEPTH = SAMPLES_PER_SYMBOL * SYMBOL_SPAN;
  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int SW   = COEF_WIDTH + $clog2(SYMBOL_SPAN) + 1; // signed coef sum
  localparam int YW   = SW - COEF_WIDTH + 18;                 // unsaturated baseband
  localparam int DW   = YW + 1;                               // demodulated value
  localparam int XW   = DW + 1;                               // gained biquad input
  localparam int NXW  = XW + 2;                               // 2*x1 + x2
  localparam int NW   = XW + 3;                               // xg + 2*x1 + x2
  localparam int MA0  = (SW > DW) ? SW : DW;
  localparam int MA   = (MA0 > LPF_Y_W) ? MA0 : LPF_Y_W;      // multiplier A side
  localparam int PW   = MA + LPF_COEF_W;                      // product
  localparam int FBW  = LPF_COEF_W + LPF_Y_W + 1;             // feedback sum
  localparam int ACW0 = (NW + 16 > FBW) ? NW + 16 : FBW;
  localparam int ACCW = ACW0 + 1;                             // biquad accumulator
  localparam int RW   = ACCW - 16;                            // rounded biquad output

  localparam logic signed [PW-1:0]   RND_B = PW'(1) << (COEF_WIDTH - 2);
  localparam logic signed [PW-1:0]   RND_G = PW'(1) << 15;
  localparam logic signed [ACCW-1:0] RND_Y = ACCW'(1) << 15;

  localparam logic signed [RW-1:0]      Y32_MAX = RW'(32'sh7fff_ffff);
  localparam logic signed [RW-1:0]      Y32_MIN = RW'(32'sh8000_0000);
  localparam logic signed [YW-1:0]      YB_MAX  = YW'(16'sh7fff);
  localparam logic signed [YW-1:0]      YB_MIN  = YW'(16'sh8000);
  localparam logic signed [LPF_Y_W-1:0] YF_MAX  = LPF_Y_W'(16'sh7fff);
  localparam logic signed [LPF_Y_W-1:0] YF_MIN  = LPF_Y_W'(16'sh8000);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_TAPS     = 10'b00_0000_0010,
    S_MUL_AMP  = 10'b00_0000_0100,
    S_MUL_A1   = 10'b00_0000_1000,
    S_MUL_A2   = 10'b00_0001_0000,
    S_MUL_GAIN = 10'b00_0010_0000,
    S_XG       = 10'b00_0100_0000,
    S_SUM      = 10'b00_1000_0000,
    S_ROUND    = 10'b01_0000_0000,
    S_OUT      = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  // registers
  logic [AMP_W-1:0]             amp;
  logic [GAIN_W-1:0]            gain;
  logic signed [LPF_COEF_W-1:0] a1;
  logic signed [LPF_COEF_W-1:0] a2;

  // modulator and filter state
  level_t                    hist [SYMBOL_SPAN];
  logic [PHASE_W-1:0]        phase;
  logic [PHASE_W-1:0]        phase_next;
  logic signed [XW-1:0]      x1;
  logic signed [XW-1:0]      x2;
  logic signed [LPF_Y_W-1:0] y1;
  logic signed [LPF_Y_W-1:0] y2;

  // datapath
  logic                       in_xfer;
  logic                       coef_wr;
  logic                       taps_start;
  logic                       taps_done;
  logic signed [SW-1:0]       csum;
  logic signed [MA-1:0]       mul_a;
  logic signed [LPF_COEF_W-1:0] mul_b;
  logic signed [PW-1:0]       mul_p;
  logic signed [YW-1:0]       yb;
  logic signed [DW-1:0]       demod;
  logic                       carrier_on;
  logic signed [NXW-1:0]      nx;
  logic signed [FBW-1:0]      fb;
  logic signed [XW-1:0]       xg;
  logic signed [ACCW-1:0]     acc;
  logic signed [PW-1:0]       yb_sum;
  logic signed [PW-1:0]       xg_sum;
  logic signed [NW-1:0]       num_sum;
  logic signed [ACCW-1:0]     yr_sum;
  logic signed [RW-1:0]       yr;
  logic signed [LPF_Y_W-1:0]  yf;
  logic                       out_free;

  assign in_ready   = (state == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign taps_start = in_xfer && (operation == OP_SAMPLE);
  // loads past the end of the store are dropped
  assign coef_wr    = in_xfer && (operation == OP_LOAD)
                      && (32'(coef_index) < 32'(STORE_DEPTH));
  assign out_free   = !out_valid || out_ready;

  bpsk_md_taps #(
    .SAMPLES_PER_SYMBOL (SAMPLES_PER_SYMBOL),
    .SYMBOL_SPAN        (SYMBOL_SPAN),
    .COEF_WIDTH         (COEF_WIDTH)
  ) u_taps (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (coef_wr),
    .wr_addr (AW'(coef_index)),
    .wr_data (COEF_WIDTH'(coef_value)),
    .start   (taps_start),
    .phase   (phase),
    .hist    (hist),
    .done    (taps_done),
    .csum    (csum)
  );

  // phase after this sample; the carrier {1,0,-1,0} squared is 1 on even phases
  assign phase_next = (phase == PHASE_W'(SAMPLES_PER_SYMBOL - 1)) ? '0 : phase + PHASE_W'(1);
  assign carrier_on = !phase_next[0];
  assign demod      = carrier_on ? {yb, 1'b0} : '0;

  // rounding of the three scaled results (floor after adding half)
  always_comb begin
    yb_sum  = mul_p + RND_B;
    xg_sum  = mul_p + RND_G;
    num_sum = NW'(xg) + NW'(nx);
    yr_sum  = acc + RND_Y;
    yr      = RW'(yr_sum >>> 16);
    if (yr > Y32_MAX) begin
      yf = LPF_Y_W'(Y32_MAX);
    end else if (yr < Y32_MIN) begin
      yf = LPF_Y_W'(Y32_MIN);
    end else begin
      yf = LPF_Y_W'(yr);
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MUL_AMP: begin
        mul_a = MA'(csum);
        mul_b = LPF_COEF_W'(amp);
      end
      S_MUL_A1: begin
        mul_a = MA'(y1);
        mul_b = a1;
      end
      S_MUL_A2: begin
        mul_a = MA'(y2);
        mul_b = a2;
      end
      S_MUL_GAIN: begin
        mul_a = MA'(demod);
        mul_b = LPF_COEF_W'(gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (taps_start) state_next = S_TAPS;
      S_TAPS:     if (taps_done) state_next = S_MUL_AMP;
      S_MUL_AMP:  state_next = S_MUL_A1;
      S_MUL_A1:   state_next = S_MUL_A2;
      S_MUL_A2:   state_next = S_MUL_GAIN;
      S_MUL_GAIN: state_next = S_XG;
      S_XG:       state_next = S_SUM;
      S_SUM:      state_next = S_ROUND;
      S_ROUND:    state_next = S_OUT;
      S_OUT:      if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      phase     <= '0;
      x1        <= '0;
      x2        <= '0;
      y1        <= '0;
      y2        <= '0;
      amp       <= AMP_RESET;
      gain      <= GAIN_RESET;
      a1        <= A1_RESET;
      a2        <= A2_RESET;
      for (int t = 0; t < SYMBOL_SPAN; t++) begin
        hist[t] <= LVL_EMPTY;
      end
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SYMBOL_AMPLITUDE: amp  <= cfg_data[AMP_W-1:0];
          REG_LPF_GAIN:         gain <= cfg_data[GAIN_W-1:0];
          REG_LPF_A1:           a1   <= cfg_data;
          REG_LPF_A2:           a2   <= cfg_data;
        endcase
      end

      // new symbol enters at phase 0
      if (taps_start && (phase == '0)) begin
        hist[0] <= symbol_bit ? LVL_POS : LVL_NEG;
      end

      if (state == S_ROUND) begin
        phase <= phase_next;
        // symbol boundary: history moves one place, newest keeps its level
        if (phase_next == '0) begin
          for (int t = SYMBOL_SPAN - 1; t > 0; t--) begin
            hist[t] <= hist[t-1];
          end
        end
        x2 <= x1;
        x1 <= xg;
        y2 <= y1;
        y1 <= yf;
      end

      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // arithmetic pipeline through the shared multiplier
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    unique case (state)
      S_MUL_A1: begin
        yb <= YW'(yb_sum >>> (COEF_WIDTH - 1));     // amplitude product ready
        nx <= (NXW'(x1) <<< 1) + NXW'(x2);
      end
      S_MUL_A2:   fb <= -FBW'(mul_p);              // a1*y1 ready
      S_MUL_GAIN: fb <= fb - FBW'(mul_p);          // a2*y2 ready
      S_XG:       xg <= XW'(xg_sum >>> 16);        // gain*d ready; never beyond 32 bits
      S_SUM:      acc <= (ACCW'(num_sum) <<< 16) + ACCW'(fb);
      default: begin
      end
    endcase
    if ((state == S_OUT) && out_free) begin
      if (yb > YB_MAX) begin
        baseband_sample <= 16'sh7fff;
      end else if (yb < YB_MIN) begin
        baseband_sample <= 16'sh8000;
      end else begin
        baseband_sample <= SAMPLE_W'(yb);
      end
      if (y1 > YF_MAX) begin
        recovered_sample <= 16'sh7fff;
      end else if (y1 < YF_MIN) begin
        recovered_sample <= 16'sh8000;
      end else begin
        recovered_sample <= SAMPLE_W'(y1);
      end
    end
  end

endmodule

// File: src/bpsk_md_checker.sv
// Port-level assertions for the BPSK modulator and its bind to the top level.
`timescale 1ns / 1ps

module bpsk_md_checker
  import bpsk_md_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       operation,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] baseband_sample,
  input logic signed [SAMPLE_W-1:0] recovered_sample
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(baseband_sample)
                                && $stable(recovered_sample))
    else $error("result changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // a sample transfer takes the block out of idle and drops in_ready
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_SAMPLE) |=> !in_ready)
    else $error("input taken while a sample is in progress");

  // no result can appear the cycle after a sample is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_SAMPLE) |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind bpsk_impulse_modulator_demod bpsk_md_checker u_bpsk_md_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .operation        (operation),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .baseband_sample  (baseband_sample),
  .recovered_sample (recovered_sample)
);
